FILE: sv/lss_pkg.sv
// ---------------------------------------------------------------------------
// lss_pkg
// Shared types, widths and helpers for the screen-size level-of-detail block.
// ---------------------------------------------------------------------------
package lss_pkg;

  localparam int CoordW = 24;
  localparam int SizeW  = 24;
  localparam int D2W    = 50;
  localparam int E2W    = 52;
  localparam int RootW  = 26;
  localparam int RemW   = 27;
  localparam int ProdW  = 49;
  localparam int QuotW  = 25;

  localparam logic [SizeW-1:0] SIZE_ONE = 24'd65536;
  localparam logic [SizeW-1:0] SIZE_SAT = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CFG_CAM_X = 2'd0,
    CFG_CAM_Y = 2'd1,
    CFG_CAM_Z = 2'd2,
    CFG_PROJ  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    DEC_CULL   = 2'd0,
    DEC_RENDER = 2'd1,
    DEC_REFINE = 2'd2
  } decision_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [SizeW-1:0]         lower_screen_size;
    logic [SizeW-1:0]         upper_screen_size;
    logic                     has_children;
  } box_t;

  // thresholds and flag that ride along with the arithmetic
  typedef struct packed {
    logic [SizeW-1:0] lower;
    logic [SizeW-1:0] upper;
    logic             kids;
  } side_t;

  typedef struct packed {
    logic [E2W-1:0] d2;
    logic [E2W-1:0] e2;
    logic           in_sphere;
    side_t          side;
  } root_in_t;

  typedef struct packed {
    logic [RootW-1:0] dq;
    logic [RootW-1:0] eq;
    logic             in_sphere;
    side_t            side;
  } root_out_t;

  typedef struct packed {
    logic [SizeW-1:0] screen_size;
    decision_t        decision;
  } result_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_acc_t;

  // one digit of the bitwise integer square root
  function automatic sqrt_acc_t sqrt_step(input logic [RemW-1:0] rem,
                                          input logic [1:0] pair,
                                          input logic [RootW-1:0] root);
    logic [RemW+1:0] acc;
    logic [RemW+1:0] trial;
    sqrt_acc_t       res;
    acc   = {rem, pair};
    trial = {1'b0, root, 2'b01};
    if (acc >= trial) begin
      res.rem  = RemW'(acc - trial);
      res.root = {root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = RemW'(acc);
      res.root = {root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

FILE: sv/lss_if.sv
// ---------------------------------------------------------------------------
// lss_box_if / lss_lod_if
// Valid/ready channels for node boxes in and size/decision results out.
// ---------------------------------------------------------------------------
interface lss_box_if;
  logic                              valid;
  logic                              ready;
  logic signed [lss_pkg::CoordW-1:0] min_x;
  logic signed [lss_pkg::CoordW-1:0] min_y;
  logic signed [lss_pkg::CoordW-1:0] min_z;
  logic signed [lss_pkg::CoordW-1:0] max_x;
  logic signed [lss_pkg::CoordW-1:0] max_y;
  logic signed [lss_pkg::CoordW-1:0] max_z;
  logic [lss_pkg::SizeW-1:0]         lower_screen_size;
  logic [lss_pkg::SizeW-1:0]         upper_screen_size;
  logic                              has_children;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  lower_screen_size, upper_screen_size, has_children,
                  input ready);
  modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                lower_screen_size, upper_screen_size, has_children,
                output ready);
endinterface

interface lss_lod_if;
  logic                      valid;
  logic                      ready;
  logic [lss_pkg::SizeW-1:0] screen_size;
  logic [1:0]                decision;

  modport source (output valid, screen_size, decision, input ready);
  modport sink (input valid, screen_size, decision, output ready);
endinterface

FILE: sv/lss_prep.sv
// ---------------------------------------------------------------------------
// lss_prep
// Four stages: axis differences, squares, sums, inside-sphere compare.
// ---------------------------------------------------------------------------
module lss_prep (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  lss_pkg::box_t                     in_box,
  input  logic signed [lss_pkg::CoordW-1:0] cam_x,
  input  logic signed [lss_pkg::CoordW-1:0] cam_y,
  input  logic signed [lss_pkg::CoordW-1:0] cam_z,
  output logic                              out_valid,
  output lss_pkg::root_in_t                 out_data
);
  import lss_pkg::*;

  logic signed [CoordW-1:0] lo [3];
  logic signed [CoordW-1:0] hi [3];
  logic signed [CoordW-1:0] cm [3];

  logic               v1, v2, v3, v4;
  logic signed [24:0] dd [3];
  logic signed [26:0] ee [3];
  side_t              side1, side2, side3, side4;
  logic [47:0]        sqd [3];
  logic [50:0]        sqe [3];
  logic [D2W-1:0]     d2s;
  logic [E2W-1:0]     e2s;
  logic [D2W-1:0]     d2f;
  logic [E2W-1:0]     e2f;
  logic               in_sphere;
  logic signed [49:0] pd [3];
  logic signed [53:0] pe [3];

  assign lo = '{in_box.min_x, in_box.min_y, in_box.min_z};
  assign hi = '{in_box.max_x, in_box.max_y, in_box.max_z};
  assign cm = '{cam_x, cam_y, cam_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd[i] = dd[i] * dd[i];
      pe[i] = ee[i] * ee[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd[i]  <= {hi[i][CoordW-1], hi[i]} - {lo[i][CoordW-1], lo[i]};
        // doubled offset from camera to box centre
        ee[i]  <= {{3{lo[i][CoordW-1]}}, lo[i]} + {{3{hi[i][CoordW-1]}}, hi[i]}
                  - {{2{cm[i][CoordW-1]}}, cm[i], 1'b0};
        sqd[i] <= pd[i][47:0];
        sqe[i] <= pe[i][50:0];
      end
      side1 <= '{lower: in_box.lower_screen_size, upper: in_box.upper_screen_size,
                 kids: in_box.has_children};
      side2 <= side1;
      d2s   <= D2W'(sqd[0]) + D2W'(sqd[1]) + D2W'(sqd[2]);
      e2s   <= E2W'(sqe[0]) + E2W'(sqe[1]) + E2W'(sqe[2]);
      side3 <= side2;
      d2f       <= d2s;
      e2f       <= e2s;
      in_sphere <= (e2s <= E2W'(d2s));
      side4     <= side3;
    end
  end

  assign out_valid          = v4;
  assign out_data.d2        = E2W'(d2f);
  assign out_data.e2        = e2f;
  assign out_data.in_sphere = in_sphere;
  assign out_data.side      = side4;

endmodule

FILE: sv/lss_sqrt.sv
// ---------------------------------------------------------------------------
// lss_sqrt
// Two-lane pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module lss_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  lss_pkg::root_in_t  in_data,
  output logic               out_valid,
  output lss_pkg::root_out_t out_data
);
  import lss_pkg::*;

  logic             v      [RootW];
  logic [E2W-1:0]   rad_d  [RootW];
  logic [E2W-1:0]   rad_e  [RootW];
  logic [RemW-1:0]  rem_d  [RootW];
  logic [RemW-1:0]  rem_e  [RootW];
  logic [RootW-1:0] root_d [RootW];
  logic [RootW-1:0] root_e [RootW];
  logic             ins    [RootW];
  side_t            side   [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic             pv;
    logic [E2W-1:0]   prd, pre;
    logic [RemW-1:0]  prmd, prme;
    logic [RootW-1:0] ptd, pte;
    logic             pins;
    side_t            pside;
    sqrt_acc_t        nd, ne;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prd   = in_data.d2;
      assign pre   = in_data.e2;
      assign prmd  = '0;
      assign prme  = '0;
      assign ptd   = '0;
      assign pte   = '0;
      assign pins  = in_data.in_sphere;
      assign pside = in_data.side;
    end else begin : g_next
      assign pv    = v[k-1];
      assign prd   = rad_d[k-1];
      assign pre   = rad_e[k-1];
      assign prmd  = rem_d[k-1];
      assign prme  = rem_e[k-1];
      assign ptd   = root_d[k-1];
      assign pte   = root_e[k-1];
      assign pins  = ins[k-1];
      assign pside = side[k-1];
    end

    assign nd = sqrt_step(prmd, prd[E2W-1 -: 2], ptd);
    assign ne = sqrt_step(prme, pre[E2W-1 -: 2], pte);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_d[k]  <= {prd[E2W-3:0], 2'b00};
        rad_e[k]  <= {pre[E2W-3:0], 2'b00};
        rem_d[k]  <= nd.rem;
        rem_e[k]  <= ne.rem;
        root_d[k] <= nd.root;
        root_e[k] <= ne.root;
        ins[k]    <= pins;
        side[k]   <= pside;
      end
    end
  end

  assign out_valid          = v[RootW-1];
  assign out_data.dq        = root_d[RootW-1];
  assign out_data.eq        = root_e[RootW-1];
  assign out_data.in_sphere = ins[RootW-1];
  assign out_data.side      = side[RootW-1];

endmodule

FILE: sv/lss_div.sv
// ---------------------------------------------------------------------------
// lss_div
// Scale by projection, pipelined restoring divide with saturation, inside-sphere override, decision.
// ---------------------------------------------------------------------------
module lss_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  lss_pkg::root_out_t       in_data,
  input  logic [lss_pkg::SizeW-1:0] proj,
  output logic                     out_valid,
  output lss_pkg::result_t         out_data
);
  import lss_pkg::*;

  // multiply stage
  logic             mv;
  logic [ProdW-1:0] mprod;
  logic [RootW-1:0] meq;
  logic             mins;
  side_t            mside;

  // overflow check stage
  logic             ov_v;
  logic [RootW-1:0] ov_rem;
  logic [QuotW-1:0] ov_low;
  logic [RootW-1:0] ov_eq;
  logic             ov_flag;
  logic             ov_ins;
  side_t            ov_side;
  logic [RootW-1:0] eq_nz;

  // divide steps
  logic             v    [QuotW];
  logic [RootW-1:0] rem  [QuotW];
  logic [QuotW-1:0] low  [QuotW];
  logic [QuotW-1:0] quo  [QuotW];
  logic [RootW-1:0] dvs  [QuotW];
  logic             ovf  [QuotW];
  logic             ins  [QuotW];
  side_t            side [QuotW];

  // final stage
  logic             fv;
  result_t          fres;
  logic [SizeW-1:0] size;
  decision_t        dec;

  assign eq_nz = (meq == '0) ? RootW'(1) : meq;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv   <= 1'b0;
      ov_v <= 1'b0;
    end else if (en) begin
      mv   <= in_valid;
      ov_v <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mprod   <= in_data.dq[QuotW-1:0] * proj;
      meq     <= in_data.eq;
      mins    <= in_data.in_sphere;
      mside   <= in_data.side;
      // quotient would need more than QuotW bits
      ov_flag <= ({2'b00, mprod[ProdW-1:QuotW]} >= eq_nz);
      ov_rem  <= {2'b00, mprod[ProdW-1:QuotW]};
      ov_low  <= mprod[QuotW-1:0];
      ov_eq   <= eq_nz;
      ov_ins  <= mins;
      ov_side <= mside;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic             pv;
    logic [RootW-1:0] prem;
    logic [QuotW-1:0] plow, pquo;
    logic [RootW-1:0] pdvs;
    logic             povf, pins;
    side_t            pside;
    logic [RootW:0]   acc;
    logic             take;

    if (k == 0) begin : g_first
      assign pv    = ov_v;
      assign prem  = ov_rem;
      assign plow  = ov_low;
      assign pquo  = '0;
      assign pdvs  = ov_eq;
      assign povf  = ov_flag;
      assign pins  = ov_ins;
      assign pside = ov_side;
    end else begin : g_next
      assign pv    = v[k-1];
      assign prem  = rem[k-1];
      assign plow  = low[k-1];
      assign pquo  = quo[k-1];
      assign pdvs  = dvs[k-1];
      assign povf  = ovf[k-1];
      assign pins  = ins[k-1];
      assign pside = side[k-1];
    end

    assign acc  = {prem, plow[QuotW-1]};
    assign take = (acc >= {1'b0, pdvs});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? RootW'(acc - {1'b0, pdvs}) : RootW'(acc);
        low[k]  <= {plow[QuotW-2:0], 1'b0};
        quo[k]  <= {pquo[QuotW-2:0], take};
        dvs[k]  <= pdvs;
        ovf[k]  <= povf;
        ins[k]  <= pins;
        side[k] <= pside;
      end
    end
  end

  always_comb begin
    if (ins[QuotW-1]) begin
      size = SIZE_ONE;
    end else if (ovf[QuotW-1] || quo[QuotW-1][QuotW-1]) begin
      size = SIZE_SAT;
    end else begin
      size = quo[QuotW-1][SizeW-1:0];
    end
    // cull test takes priority even with thresholds out of order
    priority if (size < side[QuotW-1].lower) begin
      dec = DEC_CULL;
    end else if (side[QuotW-1].kids && size >= side[QuotW-1].upper) begin
      dec = DEC_REFINE;
    end else begin
      dec = DEC_RENDER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= v[QuotW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fres.screen_size <= size;
      fres.decision    <= dec;
    end
  end

  assign out_valid = fv;
  assign out_data  = fres;

endmodule

FILE: sv/lod_screen_size_select_core.sv
// ---------------------------------------------------------------------------
// lod_screen_size_select_core
// Bounding-sphere screen size and cull/render/refine decision per node.
// ---------------------------------------------------------------------------
// throughput: one node per cycle while the spare output slot is free; 58 register
//   stages, including the 26 stages of the square root and the 25 stages of the divide
// a two-entry output buffer keeps the pipeline moving while a result waits
// reset: pipeline and output empty, camera at origin, projection scale 0.5
module lod_screen_size_select_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [lss_pkg::SizeW-1:0]        cfg_data,
  lss_box_if.sink                          box,
  lss_lod_if.source                        lod
);
  import lss_pkg::*;

  logic signed [CoordW-1:0] cam_x, cam_y, cam_z;
  logic [SizeW-1:0]         proj;

  box_t      in_box;
  logic      en;
  logic      pv, sv, dv;
  root_in_t  pdata;
  root_out_t sdata;
  result_t   ddata;

  logic      out_v, spare_v;
  result_t   out_r, spare_r;
  logic      push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      proj  <= 24'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CAM_X: cam_x <= cfg_data;
        CFG_CAM_Y: cam_y <= cfg_data;
        CFG_CAM_Z: cam_z <= cfg_data;
        CFG_PROJ:  proj  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_box = '{min_x: box.min_x, min_y: box.min_y, min_z: box.min_z,
                    max_x: box.max_x, max_y: box.max_y, max_z: box.max_z,
                    lower_screen_size: box.lower_screen_size,
                    upper_screen_size: box.upper_screen_size,
                    has_children: box.has_children};

  // pipeline advances whenever the spare slot is free
  assign en        = !spare_v;
  assign box.ready = en;

  lss_prep u_prep (
    .clk, .rst, .en,
    .in_valid  (box.valid),
    .in_box    (in_box),
    .cam_x, .cam_y, .cam_z,
    .out_valid (pv),
    .out_data  (pdata)
  );

  lss_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (pv),
    .in_data   (pdata),
    .out_valid (sv),
    .out_data  (sdata)
  );

  lss_div u_div (
    .clk, .rst, .en,
    .in_valid  (sv),
    .in_data   (sdata),
    .proj      (proj),
    .out_valid (dv),
    .out_data  (ddata)
  );

  assign push = en && dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v   <= 1'b0;
      spare_v <= 1'b0;
    end else if (lod.ready || !out_v) begin
      if (spare_v) begin
        out_v   <= 1'b1;
        spare_v <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      spare_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lod.ready || !out_v) begin
      out_r <= spare_v ? spare_r : ddata;
    end else if (push) begin
      spare_r <= ddata;
    end
  end

  assign lod.valid       = out_v;
  assign lod.screen_size = out_r.screen_size;
  assign lod.decision    = out_r.decision;

endmodule

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Checks the screen-size level-of-detail core against a behavioral
// predictor: directed boxes, several camera/projection settings, then
// random nodes under several idle and stall mixes.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import lss_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [SizeW-1:0] cfg_data;

  lss_box_if box ();
  lss_lod_if lod ();

  lod_screen_size_select_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .box(box.sink), .lod(lod.source)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // predictor state
  logic signed [23:0] cam_x, cam_y, cam_z;
  logic [23:0] proj_scale;
  result_t expected_lod[$];

  int errors;
  int nodes_sent;
  int results_seen;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  logic timed_out;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_t predict_lod(input box_t n);
    longint lo[3], hi[3], cm[3];
    longint dd, e;
    logic [63:0] d2, e2, dq, eq, sz;
    result_t r;
    d2 = 0;
    e2 = 0;
    lo[0] = n.min_x; lo[1] = n.min_y; lo[2] = n.min_z;
    hi[0] = n.max_x; hi[1] = n.max_y; hi[2] = n.max_z;
    cm[0] = cam_x; cm[1] = cam_y; cm[2] = cam_z;
    for (int i = 0; i < 3; i++) begin
      dd = hi[i] - lo[i];
      e = lo[i] + hi[i] - 2 * cm[i];
      d2 += dd * dd;
      e2 += e * e;
    end
    if (e2 <= d2) begin
      sz = 64'd65536;
    end else begin
      dq = isqrt(d2);
      eq = isqrt(e2);
      if (eq == 0) eq = 1;
      sz = (dq * proj_scale) / eq;
      if (sz > 64'hFFFFFF) sz = 64'hFFFFFF;
    end
    r.screen_size = sz[23:0];
    if (sz[23:0] < n.lower_screen_size) r.decision = DEC_CULL;
    else if (n.has_children && sz[23:0] < n.upper_screen_size) r.decision = DEC_RENDER;
    else if (n.has_children) r.decision = DEC_REFINE;
    else r.decision = DEC_RENDER;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && lod.valid && lod.ready) begin
      if (expected_lod.size() == 0) begin
        report_mismatch("unexpected result", lod.screen_size, 24'd0);
      end else begin
        if (lod.screen_size !== expected_lod[0].screen_size)
          report_mismatch("screen_size", lod.screen_size, expected_lod[0].screen_size);
        if (lod.decision !== expected_lod[0].decision)
          report_mismatch("decision", 24'(lod.decision), 24'(expected_lod[0].decision));
        void'(expected_lod.pop_front());
      end
      results_seen++;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) lod.ready <= 1'b0;
    else lod.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (box.valid && box.ready) || (lod.valid && lod.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("FAIL lod_screen_size_select_core");
      $finish;
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CAM_X: cam_x = val;
      CFG_CAM_Y: cam_y = val;
      CFG_CAM_Z: cam_z = val;
      CFG_PROJ:  proj_scale = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    box.valid <= 1'b0;
    while (expected_lod.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_node(input box_t n);
    while ($urandom_range(99) < send_idle_pct) begin
      box.valid <= 1'b0;
      @(posedge clk);
    end
    box.valid <= 1'b1;
    box.min_x <= n.min_x; box.min_y <= n.min_y; box.min_z <= n.min_z;
    box.max_x <= n.max_x; box.max_y <= n.max_y; box.max_z <= n.max_z;
    box.lower_screen_size <= n.lower_screen_size;
    box.upper_screen_size <= n.upper_screen_size;
    box.has_children <= n.has_children;
    @(posedge clk);
    while (!box.ready) @(posedge clk);
    expected_lod = {expected_lod, predict_lod(n)};
    nodes_sent++;
  endtask

  function automatic logic [23:0] rand_small_coord(input int span);
    return 24'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic box_t rand_node(input int span);
    box_t n;
    logic [23:0] c;
    n.min_x = rand_small_coord(span); n.min_y = rand_small_coord(span);
    n.min_z = rand_small_coord(span);
    n.max_x = n.min_x + 24'($urandom_range(span)); n.max_y = n.min_y + 24'($urandom_range(span));
    n.max_z = n.min_z + 24'($urandom_range(span));
    if ($urandom_range(7) == 0) begin
      n.min_x = 24'($urandom); n.max_y = 24'($urandom); n.max_z = 24'($urandom);
    end
    c = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(131072));
    n.lower_screen_size = c;
    n.upper_screen_size = $urandom_range(3) == 0 ? 24'($urandom) : c + 24'($urandom_range(131072));
    n.has_children = 1'($urandom_range(1));
    return n;
  endfunction

  task automatic test_directed();
    box_t n;
    n = '0;
    send_node(n);                                  // point box at camera
    n.max_x = 24'sh7FFFFF; n.max_y = 24'sh7FFFFF; n.max_z = 24'sh7FFFFF;
    n.min_x = 24'sh800000; n.min_y = 24'sh800000; n.min_z = 24'sh800000;
    send_node(n);                                  // full range box
    n.has_children = 1'b1; n.upper_screen_size = 24'hFFFFFF;
    send_node(n);
    n = '0; n.min_x = 24'sh7FFFFF; n.max_x = 24'sh7FFFFF;
    send_node(n);                                  // far point, size 0
    n.lower_screen_size = 24'd1;
    send_node(n);                                  // culled
    n = '0; n.min_x = 24'sh800000; n.max_x = 24'sh800000; n.max_y = 24'd256;
    n.has_children = 1'b1;
    send_node(n);
    // inverted box, same as a normal one
    n = '0; n.min_x = 24'sd5000; n.max_x = 24'sd4000; n.min_y = 24'sd100;
    n.max_y = -24'sd100; n.has_children = 1'b1; n.upper_screen_size = 24'd10;
    send_node(n);
    // thresholds out of order
    n.lower_screen_size = 24'hFFFFFF; n.upper_screen_size = 24'd0;
    send_node(n);
    n.lower_screen_size = 24'd0; n.upper_screen_size = 24'd0;
    send_node(n);
    n.has_children = 1'b0; n.upper_screen_size = 24'hFFFFFF;
    send_node(n);
    // camera outside the sphere, at twice its radius from the box centre
    n = '0; n.min_x = -24'sd300; n.max_x = 24'sd300; n.min_y = 24'sd600;
    n.max_y = 24'sd600;
    send_node(n);
    n.lower_screen_size = 24'd65536; n.upper_screen_size = 24'd65537;
    n.has_children = 1'b1;
    send_node(n);
    n.upper_screen_size = 24'd65536;
    send_node(n);
  endtask

  task automatic test_settings();
    write_reg(CFG_PROJ, 24'hFFFFFF);
    write_reg(CFG_CAM_X, 24'sh7FFFFF);
    write_reg(CFG_CAM_Y, 24'sh800000);
    write_reg(CFG_CAM_Z, 24'sh7FFFFF);
    repeat (10) send_node(rand_node(8000000));
    wait_drained();
    write_reg(CFG_PROJ, 24'd0);
    write_reg(CFG_CAM_X, 24'sh800000);
    write_reg(CFG_CAM_Y, 24'sh7FFFFF);
    write_reg(CFG_CAM_Z, 24'sh800000);
    repeat (10) send_node(rand_node(8000000));
    wait_drained();
  endtask

  task automatic test_random(input int count, input int sidle, input int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    write_reg(CFG_CAM_X, rand_small_coord(20000));
    write_reg(CFG_CAM_Y, rand_small_coord(20000));
    write_reg(CFG_CAM_Z, $urandom_range(3) == 0 ? 24'($urandom) : rand_small_coord(20000));
    write_reg(CFG_PROJ, $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(200000)));
    for (int i = 0; i < count; i++)
      send_node(rand_node($urandom_range(1) ? 20000 : 8000000));
    wait_drained();
  endtask

  initial begin
    errors = 0; nodes_sent = 0; results_seen = 0; idle_cycles = 0;
    timed_out = 1'b0; send_idle_pct = 0; recv_stall_pct = 0;
    cam_x = 0; cam_y = 0; cam_z = 0; proj_scale = 24'd32768;
    rst <= 1'b1; cfg_we <= 1'b0; cfg_index <= CFG_CAM_X; cfg_data <= '0;
    box.valid <= 1'b0; box.min_x <= '0; box.min_y <= '0; box.min_z <= '0;
    box.max_x <= '0; box.max_y <= '0; box.max_z <= '0;
    box.lower_screen_size <= '0; box.upper_screen_size <= '0; box.has_children <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_settings();
    test_random(200, 0, 0);
    test_random(200, 58, 0);
    test_random(200, 0, 58);
    test_random(200, 35, 35);
    $display("covered %0d nodes, %0d results, directed edges and 6 register settings",
             nodes_sent, results_seen);
    if (errors == 0) begin
      $display("PASS lod_screen_size_select_core");
    end else begin
      $display("FAIL lod_screen_size_select_core");
    end
    $finish;
  end

endmodule
